### hdl/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
package rau_pkg;

  localparam int unsigned WordBitsDef = 64;
  localparam int unsigned FieldBits = 64;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_NEG    = 3'd4,
    OP_EQ     = 3'd5,
    OP_LT     = 3'd6,
    OP_REBASE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    UC_MUL = 2'd0,
    UC_DIV = 2'd1,
    UC_GCD = 2'd2
  } unit_cmd_e;

  typedef struct packed {
    logic      start;
    unit_cmd_e cmd;
  } unit_req_t;

  typedef struct packed {
    op_e                    op;
    logic signed [FieldBits-1:0] left_num;
    logic signed [FieldBits-1:0] left_den;
    logic signed [FieldBits-1:0] right_num;
    logic signed [FieldBits-1:0] right_den;
  } in_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] res_num;
    logic signed [FieldBits-1:0] res_den;
    logic                        flag;
    logic                        error;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_AS_GCD,
    ST_AS_B1,
    ST_AS_B2,
    ST_AS_DEN,
    ST_AS_T1,
    ST_AS_T2,
    ST_AS_SUM,
    ST_MD_NUM,
    ST_MD_DEN,
    ST_RD_CHK,
    ST_RD_GCD,
    ST_RD_N,
    ST_RD_D,
    ST_RD_FIN,
    ST_CM_GCD,
    ST_CM_X,
    ST_CM_Y,
    ST_CM_N1,
    ST_CM_N2,
    ST_CM_FLAG,
    ST_RB_PROD,
    ST_RB_DIV,
    ST_DONE
  } state_e;

endpackage

### hdl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: one item in, one result out, two signed fractions per item.
// One item is worked at a time; in_ready_o is high only while the sequencer is idle.
// Every multiply, divide and gcd runs on one bit-serial shared unit. An add or subtract
// needs two gcds, four divides and three multiplies; multiply/divide needs two
// multiplies, a gcd and two divides, compare a gcd, two divides and two multiplies,
// and rebase one multiply and one divide. A finished result sits in an output register,
// so the next item is taken while it waits for its transfer.
module rational_arithmetic_unit_core #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::out_t out_data_o
);
  import rau_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam logic [W-1:0] TopBit = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxP   = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } sv_t;

  typedef struct packed {
    logic flt;
    sv_t  v;
  } sres_t;

  function automatic sv_t mk(input logic neg, input logic [W-1:0] mag);
    sv_t r;
    r.neg = neg && (mag != '0);
    r.mag = mag;
    return r;
  endfunction

  function automatic sv_t sneg(input sv_t x);
    return mk(!x.neg, x.mag);
  endfunction

  function automatic sv_t from_bits(input logic [FieldBits-1:0] x);
    logic [W-1:0] xw;
    xw = x[W-1:0];
    return mk(xw[W-1], xw[W-1] ? (~xw + 1'b1) : xw);
  endfunction

  function automatic logic fits(input sv_t v);
    return v.mag <= (v.neg ? TopBit : MaxP);
  endfunction

  function automatic logic signed [FieldBits-1:0] to_bits(input sv_t v);
    logic signed [W-1:0] ws;
    ws = v.neg ? (~v.mag + 1'b1) : v.mag;
    return FieldBits'(ws);
  endfunction

  function automatic sres_t sadd(input sv_t x, input sv_t y);
    sres_t      r;
    logic [W:0] s;
    logic [W-1:0] lim;
    r.flt = 1'b0;
    lim = x.neg ? TopBit : MaxP;
    s = {1'b0, x.mag} + {1'b0, y.mag};
    if (x.neg == y.neg) begin
      if (x.mag > lim || s > {1'b0, lim}) begin
        r.flt = 1'b1;
        r.v   = mk(1'b0, '0);
      end else begin
        r.v = mk(x.neg, s[W-1:0]);
      end
    end else if (x.mag >= y.mag) begin
      r.v = mk(x.neg, x.mag - y.mag);
    end else begin
      r.v = mk(y.neg, y.mag - x.mag);
    end
    if (!fits(r.v)) r.flt = 1'b1;
    return r;
  endfunction

  state_e       state_q, state_d;
  logic         pend_q, pend_d;
  op_e          op_q, op_d;
  sv_t          a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  sv_t          x_q, x_d, y_q, y_d, n_q, n_d, dn_q, dn_d;
  logic [W-1:0] g_q, g_d;
  logic         flt_q, flt_d, flag_q, flag_d;
  out_t         out_q, out_d;
  logic         out_valid_q, out_valid_d;

  unit_req_t    u_req;
  logic [W-1:0] u_a, u_b, u_hi, u_lo;
  logic         u_done;
  logic         is_call, pneg, step_done, out_load;
  sres_t        mr, sr;
  sv_t          rq, fin_n;

  rau_unit #(.W(W)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .a_i    (u_a),
    .b_i    (u_b),
    .done_o (u_done),
    .hi_o   (u_hi),
    .lo_o   (u_lo)
  );

  // unit operand select
  always_comb begin
    is_call   = 1'b1;
    u_req.cmd = UC_MUL;
    u_a       = '0;
    u_b       = '0;
    pneg      = 1'b0;
    case (state_q)
      ST_AS_GCD, ST_CM_GCD: begin
        u_req.cmd = UC_GCD; u_a = b_q.mag; u_b = d_q.mag;
      end
      ST_AS_B1, ST_CM_Y: begin
        u_req.cmd = UC_DIV; u_a = b_q.mag; u_b = g_q;
      end
      ST_AS_B2, ST_CM_X: begin
        u_req.cmd = UC_DIV; u_a = d_q.mag; u_b = g_q;
      end
      ST_AS_DEN: begin
        u_a = x_q.mag; u_b = d_q.mag; pneg = x_q.neg ^ d_q.neg;
      end
      ST_AS_T1, ST_CM_N1: begin
        u_a = a_q.mag; u_b = (state_q == ST_AS_T1) ? y_q.mag : x_q.mag;
        pneg = a_q.neg ^ ((state_q == ST_AS_T1) ? y_q.neg : x_q.neg);
      end
      ST_AS_T2: begin
        u_a = c_q.mag; u_b = x_q.mag; pneg = c_q.neg ^ x_q.neg;
      end
      ST_CM_N2: begin
        u_a = c_q.mag; u_b = y_q.mag; pneg = c_q.neg ^ y_q.neg;
      end
      ST_MD_NUM: begin
        u_a = a_q.mag; u_b = (op_q == OP_MUL) ? c_q.mag : d_q.mag;
        pneg = a_q.neg ^ ((op_q == OP_MUL) ? c_q.neg : d_q.neg);
      end
      ST_MD_DEN: begin
        u_a = b_q.mag; u_b = (op_q == OP_MUL) ? d_q.mag : c_q.mag;
        pneg = b_q.neg ^ ((op_q == OP_MUL) ? d_q.neg : c_q.neg);
      end
      ST_RB_PROD: begin
        u_a = a_q.mag; u_b = d_q.mag; pneg = a_q.neg ^ d_q.neg;
      end
      ST_RD_GCD: begin
        u_req.cmd = UC_GCD; u_a = n_q.mag; u_b = dn_q.mag;
      end
      ST_RD_N: begin
        u_req.cmd = UC_DIV; u_a = n_q.mag; u_b = g_q;
      end
      ST_RD_D: begin
        u_req.cmd = UC_DIV; u_a = dn_q.mag; u_b = g_q;
      end
      ST_RB_DIV: begin
        u_req.cmd = UC_DIV; u_a = x_q.mag; u_b = b_q.mag;
      end
      default: is_call = 1'b0;
    endcase
    u_req.start = is_call && !pend_q;
  end

  assign step_done = pend_q && u_done;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // product check, sum, final sign move and rebase quotient
  always_comb begin
    mr.flt = (u_hi != '0) || (u_lo > (pneg ? TopBit : MaxP));
    mr.v   = mr.flt ? mk(1'b0, '0) : mk(pneg, u_lo);
    sr     = sadd(y_q, x_q);
    fin_n  = dn_q.neg ? sneg(n_q) : n_q;
    rq     = mk(x_q.neg != b_q.neg, u_lo);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: begin
        case (op_q)
          OP_MUL, OP_DIV: state_d = ST_MD_NUM;
          OP_NEG:         state_d = ST_RD_CHK;
          default: begin
            if (b_q.mag == '0 || d_q.mag == '0) state_d = ST_DONE;
            else if (op_q == OP_ADD || op_q == OP_SUB) state_d = ST_AS_GCD;
            else if (op_q == OP_REBASE) state_d = ST_RB_PROD;
            else state_d = ST_CM_GCD;
          end
        endcase
      end
      ST_AS_GCD:  if (step_done) state_d = ST_AS_B1;
      ST_AS_B1:   if (step_done) state_d = ST_AS_B2;
      ST_AS_B2:   if (step_done) state_d = ST_AS_DEN;
      ST_AS_DEN:  if (step_done) state_d = flt_d ? ST_DONE : ST_AS_T1;
      ST_AS_T1:   if (step_done) state_d = flt_d ? ST_DONE : ST_AS_T2;
      ST_AS_T2:   if (step_done) state_d = flt_d ? ST_DONE : ST_AS_SUM;
      ST_AS_SUM:  state_d = flt_d ? ST_DONE : ST_RD_CHK;
      ST_MD_NUM:  if (step_done) state_d = flt_d ? ST_DONE : ST_MD_DEN;
      ST_MD_DEN:  if (step_done) state_d = flt_d ? ST_DONE : ST_RD_CHK;
      ST_RD_CHK:  state_d = flt_d ? ST_DONE : ST_RD_GCD;
      ST_RD_GCD:  if (step_done) state_d = ST_RD_N;
      ST_RD_N:    if (step_done) state_d = ST_RD_D;
      ST_RD_D:    if (step_done) state_d = ST_RD_FIN;
      ST_RD_FIN:  state_d = ST_DONE;
      ST_CM_GCD:  if (step_done) state_d = ST_CM_X;
      ST_CM_X:    if (step_done) state_d = ST_CM_Y;
      ST_CM_Y:    if (step_done) state_d = ST_CM_N1;
      ST_CM_N1:   if (step_done) state_d = flt_d ? ST_DONE : ST_CM_N2;
      ST_CM_N2:   if (step_done) state_d = flt_d ? ST_DONE : ST_CM_FLAG;
      ST_CM_FLAG: state_d = ST_DONE;
      ST_RB_PROD: if (step_done) state_d = flt_d ? ST_DONE : ST_RB_DIV;
      ST_RB_DIV:  if (step_done) state_d = ST_DONE;
      ST_DONE:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    d_d    = d_q;
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    dn_d   = dn_q;
    g_d    = g_q;
    flt_d  = flt_q;
    flag_d = flag_q;
    pend_d = u_req.start ? 1'b1 : (step_done ? 1'b0 : pend_q);
    out_d  = out_q;
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_data_i.op;
          a_d    = from_bits(in_data_i.left_num);
          b_d    = from_bits(in_data_i.left_den);
          c_d    = from_bits(in_data_i.right_num);
          d_d    = from_bits(in_data_i.right_den);
          n_d    = mk(1'b0, '0);
          dn_d   = mk(1'b0, '0);
          flt_d  = 1'b0;
          flag_d = 1'b0;
          pend_d = 1'b0;
        end
      end
      ST_PREP: begin
        case (op_q)
          OP_MUL, OP_DIV: ;
          OP_NEG: begin
            n_d  = sneg(a_q);
            dn_d = b_q;
          end
          default: begin
            if (b_q.mag == '0 || d_q.mag == '0) flt_d = 1'b1;
            if (op_q == OP_SUB) c_d = sneg(c_q);
            if (op_q == OP_EQ || op_q == OP_LT) begin
              if (b_q.neg) begin
                a_d     = sneg(a_q);
                b_d.neg = 1'b0;
              end
              if (d_q.neg) begin
                c_d     = sneg(c_q);
                d_d.neg = 1'b0;
              end
            end
          end
        endcase
      end
      ST_AS_GCD, ST_CM_GCD, ST_RD_GCD: if (step_done) g_d = u_lo;
      ST_AS_B1: if (step_done) x_d = mk(b_q.neg, u_lo);
      ST_AS_B2: if (step_done) y_d = mk(d_q.neg, u_lo);
      ST_CM_X:  if (step_done) x_d = mk(1'b0, u_lo);
      ST_CM_Y:  if (step_done) y_d = mk(1'b0, u_lo);
      ST_AS_DEN, ST_MD_DEN: begin
        if (step_done) begin
          dn_d  = mr.v;
          flt_d = mr.flt;
        end
      end
      ST_AS_T1, ST_CM_N2: begin
        if (step_done) begin
          y_d   = mr.v;
          flt_d = mr.flt;
        end
      end
      ST_AS_T2, ST_CM_N1, ST_RB_PROD: begin
        if (step_done) begin
          x_d   = mr.v;
          flt_d = mr.flt;
        end
      end
      ST_MD_NUM: begin
        if (step_done) begin
          n_d   = mr.v;
          flt_d = mr.flt;
        end
      end
      ST_AS_SUM: begin
        n_d   = sr.v;
        flt_d = sr.flt;
      end
      ST_RD_CHK: if (dn_q.mag == '0) flt_d = 1'b1;
      ST_RD_N: if (step_done) n_d = mk(n_q.neg, u_lo);
      ST_RD_D: if (step_done) dn_d.mag = u_lo;
      ST_RD_FIN: begin
        n_d   = fin_n;
        dn_d  = mk(1'b0, dn_q.mag);
        flt_d = !fits(fin_n) || !fits(mk(1'b0, dn_q.mag));
      end
      ST_CM_FLAG: begin
        if (op_q == OP_EQ) flag_d = (x_q.neg == y_q.neg) && (x_q.mag == y_q.mag);
        else if (x_q.neg != y_q.neg) flag_d = x_q.neg;
        else flag_d = x_q.neg ? (x_q.mag > y_q.mag) : (x_q.mag < y_q.mag);
      end
      ST_RB_DIV: begin
        if (step_done) begin
          if (u_hi == '0) begin
            if (!fits(rq)) begin
              flt_d = 1'b1;
            end else begin
              n_d    = rq;
              dn_d   = d_q;
              flag_d = 1'b1;
            end
          end else begin
            n_d  = a_q;
            dn_d = b_q;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          if (flt_q) begin
            out_d.res_num = '0;
            out_d.res_den = '0;
            out_d.flag    = 1'b0;
            out_d.error   = 1'b1;
          end else begin
            out_d.res_num = to_bits(n_q);
            out_d.res_den = to_bits(dn_q);
            out_d.flag    = flag_q;
            out_d.error   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    x_q    <= x_d;
    y_q    <= y_d;
    n_q    <= n_d;
    dn_q   <= dn_d;
    g_q    <= g_d;
    flt_q  <= flt_d;
    flag_q <= flag_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q) else $error("unit step pending while idle");
  a_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> pend_q) else $error("unit result nobody waits for");
  a_start_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_req.start |=> pend_q) else $error("unit started without pending step");
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |->
      (out_data_o.res_num == '0 && out_data_o.res_den == '0 && !out_data_o.flag))
    else $error("error result carries data");

endmodule

### hdl/rau_unit.sv
// bit-serial shared unit: shift-add multiply, restoring divide, binary gcd
module rau_unit #(
  parameter int unsigned W = rau_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::unit_req_t req_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output logic               done_o,
  output logic [W-1:0]       hi_o,
  output logic [W-1:0]       lo_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);
  localparam int unsigned KW   = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  unit_cmd_e       cmd_q, cmd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [KW-1:0]   k_q, k_d;
  logic [W-1:0]    hi_q, hi_d, lo_q, lo_d, b_q, b_d;
  logic [W:0]      add_s, shf_s, trl_s;
  logic [W-1:0]    gsrc;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cmd_d  = cmd_q;
    cnt_d  = cnt_q;
    k_d    = k_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    add_s  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);
    shf_s  = {hi_q, lo_q[W-1]};
    trl_s  = shf_s - {1'b0, b_q};
    gsrc   = (hi_q == '0) ? lo_q : hi_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cmd_d  = req_i.cmd;
      cnt_d  = '0;
      k_d    = '0;
      b_d    = b_i;
      case (req_i.cmd)
        UC_GCD: begin
          hi_d = a_i;
          lo_d = b_i;
        end
        default: begin
          hi_d = '0;
          lo_d = a_i;
        end
      endcase
    end else if (busy_q) begin
      case (cmd_q)
        UC_MUL: begin
          hi_d  = add_s[W:1];
          lo_d  = {add_s[0], lo_q[W-1:1]};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(W - 1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        UC_DIV: begin
          hi_d  = trl_s[W] ? shf_s[W-1:0] : trl_s[W-1:0];
          lo_d  = {lo_q[W-2:0], ~trl_s[W]};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(W - 1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        default: begin
          if (hi_q == '0 || lo_q == '0) begin
            lo_d   = gsrc << k_q;
            busy_d = 1'b0;
            done_d = 1'b1;
          end else if (!hi_q[0] && !lo_q[0]) begin
            hi_d = hi_q >> 1;
            lo_d = lo_q >> 1;
            k_d  = k_q + 1'b1;
          end else if (!hi_q[0]) begin
            hi_d = hi_q >> 1;
          end else if (!lo_q[0]) begin
            lo_d = lo_q >> 1;
          end else if (hi_q >= lo_q) begin
            hi_d = hi_q - lo_q;
          end else begin
            lo_d = lo_q - hi_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cmd_q  <= UC_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cmd_q  <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    k_q   <= k_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("unit done without work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("unit done while still busy");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench of the rational arithmetic unit: random and directed fractions, scoreboard check
module testbench;
  import rau_pkg::*;

  typedef struct {
    logic         neg;
    logic [63:0]  mag;
  } mag_t;

  localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_t out_data_o;

  bit   overflow;
  bit   quiet;
  bit   sending_done = 0;

  rational_arithmetic_unit_core dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic mag_t mk(logic neg, logic [63:0] m);
    mag_t r;
    r.neg = neg && (m != 0);
    r.mag = m;
    return r;
  endfunction

  function automatic mag_t split(logic [63:0] x);
    return x[63] ? mk(1'b1, -x) : mk(1'b0, x);
  endfunction

  function automatic logic [63:0] join_bits(mag_t v);
    return v.neg ? -v.mag : v.mag;
  endfunction

  function automatic bit in_range(mag_t v);
    return v.mag <= (v.neg ? TopBit : MaxPos);
  endfunction

  function automatic mag_t flip(mag_t v);
    return mk(!v.neg, v.mag);
  endfunction

  function automatic mag_t times(mag_t x, mag_t y);
    logic [127:0] p;
    logic neg;
    neg = x.neg != y.neg;
    p = {64'd0, x.mag} * {64'd0, y.mag};
    if (p > (neg ? {64'd0, TopBit} : {64'd0, MaxPos})) begin
      overflow = 1;
      return mk(0, 0);
    end
    return mk(neg, p[63:0]);
  endfunction

  function automatic mag_t plus(mag_t x, mag_t y);
    mag_t r;
    logic [64:0] s;
    if (x.neg == y.neg) begin
      s = {1'b0, x.mag} + {1'b0, y.mag};
      if (s > (x.neg ? {1'b0, TopBit} : {1'b0, MaxPos})) begin
        overflow = 1;
        return mk(0, 0);
      end
      r = mk(x.neg, s[63:0]);
    end else if (x.mag >= y.mag) begin
      r = mk(x.neg, x.mag - y.mag);
    end else begin
      r = mk(y.neg, y.mag - x.mag);
    end
    if (!in_range(r)) overflow = 1;
    return r;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
    logic [63:0] t;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    return u;
  endfunction

  function automatic void lowest_terms(mag_t n, mag_t d, ref mag_t rn, ref mag_t rd);
    logic [63:0] g;
    if (d.mag == 0) begin
      overflow = 1;
      return;
    end
    g = gcd_of(n.mag, d.mag);
    n = mk(n.neg, n.mag / g);
    d.mag = d.mag / g;
    if (d.neg) begin
      n = flip(n);
      d.neg = 0;
    end
    if (!in_range(n) || !in_range(d)) overflow = 1;
    rn = n;
    rd = d;
  endfunction

  function automatic out_t predict_result(in_t item);
    mag_t a, b, c, d, rn, rd, b1, b2, num, den, n1, n2, prod, q;
    logic [63:0] g;
    logic flg;
    out_t r;
    a = split(item.left_num);
    b = split(item.left_den);
    c = split(item.right_num);
    d = split(item.right_den);
    rn = mk(0, 0);
    rd = mk(0, 0);
    flg = 0;
    overflow = 0;
    case (item.op)
      OP_ADD, OP_SUB: begin
        if (item.op == OP_SUB) c = flip(c);
        if (b.mag == 0 || d.mag == 0) begin
          overflow = 1;
        end else begin
          g = gcd_of(b.mag, d.mag);
          b1 = mk(b.neg, b.mag / g);
          b2 = mk(d.neg, d.mag / g);
          den = times(b1, d);
          num = plus(times(a, b2), times(c, b1));
          if (!overflow) lowest_terms(num, den, rn, rd);
        end
      end
      OP_MUL, OP_DIV: begin
        num = times(a, item.op == OP_MUL ? c : d);
        den = times(b, item.op == OP_MUL ? d : c);
        if (!overflow) lowest_terms(num, den, rn, rd);
      end
      OP_NEG: lowest_terms(flip(a), b, rn, rd);
      OP_EQ, OP_LT: begin
        if (b.mag == 0 || d.mag == 0) begin
          overflow = 1;
        end else begin
          if (b.neg) begin
            a = flip(a);
            b.neg = 0;
          end
          if (d.neg) begin
            c = flip(c);
            d.neg = 0;
          end
          g = gcd_of(b.mag, d.mag);
          n1 = times(a, mk(0, d.mag / g));
          n2 = times(c, mk(0, b.mag / g));
          if (item.op == OP_EQ) flg = n1.neg == n2.neg && n1.mag == n2.mag;
          else if (n1.neg != n2.neg) flg = n1.neg;
          else flg = n1.neg ? (n1.mag > n2.mag) : (n1.mag < n2.mag);
        end
      end
      default: begin
        if (b.mag == 0 || d.mag == 0) begin
          overflow = 1;
        end else begin
          prod = times(a, d);
          if (!overflow) begin
            if (prod.mag % b.mag == 0) begin
              q = mk(prod.neg != b.neg, prod.mag / b.mag);
              if (!in_range(q)) begin
                overflow = 1;
              end else begin
                rn = q;
                rd = d;
                flg = 1;
              end
            end else begin
              rn = a;
              rd = b;
            end
          end
        end
      end
    endcase
    r = '0;
    if (overflow) begin
      r.error = 1;
    end else begin
      r.res_num = join_bits(rn);
      r.res_den = join_bits(rd);
      r.flag = flg;
    end
    return r;
  endfunction

  class result_board;
    out_t pending[$];
    int   fails;

    function void note_item(in_t item);
      pending.push_back(predict_result(item));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.res_num !== want.res_num) begin
        $error("res_num expected %0d actual %0d", want.res_num, got.res_num);
        fails++;
      end
      if (got.res_den !== want.res_den) begin
        $error("res_den expected %0d actual %0d", want.res_den, got.res_den);
        fails++;
      end
      if (got.flag !== want.flag) begin
        $error("flag expected %0b actual %0b", want.flag, got.flag);
        fails++;
      end
      if (got.error !== want.error) begin
        $error("error expected %0b actual %0b", want.error, got.error);
        fails++;
      end
    endfunction
  endclass

  result_board board = new();

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly small values so that results rarely overflow, some full width
  function automatic logic [63:0] pick_value();
    int unsigned k;
    logic [63:0] v;
    k = $urandom_range(0, 99);
    if (k < 55) v = 64'($urandom_range(0, 40));
    else if (k < 75) v = 64'($urandom_range(0, 100000));
    else if (k < 85) v = {32'd0, $urandom()};
    else if (k < 92) return rand64();
    else if (k < 96) return TopBit;
    else return MaxPos;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_item(in_t item);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(item);
  endtask

  task automatic send_fields(op_e op, logic [63:0] an, logic [63:0] ad,
                             logic [63:0] cn, logic [63:0] cd);
    in_t item;
    item.op = op;
    item.left_num = an;
    item.left_den = ad;
    item.right_num = cn;
    item.right_den = cd;
    send_item(item);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
      out_ready_i <= quiet || sending_done || ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    in_t item;
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int o = 0; o < 8; o++) begin
      send_fields(op_e'(o), 64'd3, 64'd4, -64'sd5, 64'd6);
    end
    send_fields(OP_ADD, TopBit, 64'd1, 64'd0, 64'd1);
    send_fields(OP_SUB, MaxPos, 64'd1, -64'sd1, 64'd1);
    send_fields(OP_MUL, TopBit, 64'd1, -64'sd1, 64'd1);
    send_fields(OP_DIV, 64'd1, 64'd2, 64'd0, 64'd5);
    send_fields(OP_NEG, TopBit, 64'd1, 64'd0, 64'd1);
    send_fields(OP_NEG, 64'd0, 64'd0, 64'd0, 64'd1);
    send_fields(OP_NEG, 64'd6, -64'sd4, 64'd0, 64'd1);
    send_fields(OP_ADD, 64'd1, 64'd0, 64'd1, 64'd1);
    send_fields(OP_LT, 64'd1, -64'sd2, 64'd1, 64'd3);
    send_fields(OP_EQ, 64'd2, 64'd4, -64'sd1, -64'sd2);
    send_fields(OP_LT, TopBit, MaxPos, MaxPos, TopBit);
    send_fields(OP_REBASE, 64'd1, 64'd3, 64'd0, 64'd6);
    send_fields(OP_REBASE, 64'd1, 64'd3, 64'd0, 64'd4);
    send_fields(OP_REBASE, 64'd1, 64'd3, 64'd0, 64'd0);
    send_fields(OP_REBASE, -64'sd2, -64'sd3, 64'd7, -64'sd6);
    send_fields(OP_ADD, 64'd1, MaxPos, 64'd1, TopBit);
    for (int i = 0; i < 850; i++) begin
      quiet = (i >= 300 && i < 400);
      item.op = op_e'($urandom_range(0, 7));
      item.left_num = pick_value();
      item.left_den = pick_value();
      item.right_num = pick_value();
      item.right_den = pick_value();
      r = $urandom_range(0, 99);
      if (r < 8) item.left_den = 0;
      else if (r < 16) item.right_den = 0;
      else if (r < 22) begin
        item.left_num = rand64();
        item.right_num = rand64();
      end
      send_item(item);
    end
    in_valid_i <= 0;
    quiet = 0;
    sending_done = 1;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.fails == 0) $display("rational_arithmetic_unit_core test passed");
    else $display("rational_arithmetic_unit_core test failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("rational_arithmetic_unit_core test failed");
    $finish;
  end

endmodule

### rational_arithmetic_unit_core.f
hdl/rau_pkg.sv
hdl/rau_unit.sv
hdl/rational_arithmetic_unit_core.sv
tb/sv/testbench.sv
